### hw/rtl/ibus_frame_decoder_top_assert.svh
// Assertion macros used by the iBUS frame decoder checker.
`ifndef IBUS_FRAME_DECODER_TOP_ASSERT_SVH
`define IBUS_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define IFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ifd checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk, off while rst is high.
`define IFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ifd checker: next-cycle rule violated");

`endif

### hw/rtl/ifd_pkg.sv
// Shared types and constants of the iBUS frame decoder.
`default_nettype none

package ifd_pkg;

  // Input item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CMD = 2'd2;

  // Register reset values
  localparam logic [7:0]  GAP_MS_RST      = 8'd3;
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;
  localparam logic [7:0]  EXPECTED_CMD_RST = 8'h40;

  // Frame constants: length byte and two checksum bytes are overhead
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd3;
  localparam logic [15:0] SUM_INIT       = 16'hFFFF;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_GOOD  = 2'd1,
    EV_BAD   = 2'd2,
    EV_OTHER = 2'd3
  } ev_t;

  // Parser state, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_DATA = 4'b0010,
    PH_CKL  = 4'b0100,
    PH_CKH  = 4'b1000
  } phase_t;

  // Per-item outcome handed from parser to result stage
  typedef struct packed {
    ev_t         ev;
    logic        link;
    logic [31:0] good;
    logic [31:0] bad;
  } item_res_t;

endpackage

`default_nettype wire

### hw/rtl/ifd_if.sv
// Channel interfaces of the iBUS frame decoder: input items, results, config writes.
`default_nettype none

interface ifd_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, command, rx_byte, now_ms, input ready);
  modport sink   (input valid, command, rx_byte, now_ms, output ready);
endinterface

interface ifd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        last;
  logic        link_ok;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;

  modport source (output valid, event_res, channel_index, channel_value, last, link_ok,
                  good_frames, bad_frames, input ready);
  modport sink   (input valid, event_res, channel_index, channel_value, last, link_ok,
                  good_frames, bad_frames, output ready);
endinterface

interface ifd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ifd_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [ifd_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/ifd_parser.sv
// Frame parser: resync, payload capture, checksum, counters and link status.
`default_nettype none

module ifd_parser #(
  parameter int CHANNELS        = 14,
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  command,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           now_ms,
  input  logic [7:0]            gap_ms,
  input  logic [15:0]           timeout_ms,
  input  logic [7:0]            expected_command,
  output ifd_pkg::item_res_t    res,
  output logic [CHANNELS-1:0]   ch_we,
  output logic [15:0]           ch_wdata [CHANNELS]
);

  localparam int STORE_AW = $clog2(MAX_FRAME_BYTES);
  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);
  localparam logic [5:0] STORE_DEPTH = 6'(MAX_FRAME_BYTES);

  ifd_pkg::phase_t phase, phase_next, cur_phase;
  logic [4:0]  payload_len, payload_len_next;
  logic [4:0]  write_pos, write_pos_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  sum_low_byte, sum_low_byte_next;
  logic [7:0]  store [MAX_FRAME_BYTES];
  logic [31:0] last_byte_time;
  logic [31:0] last_good_time, last_good_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] bad_count, bad_count_next;
  logic        seen_good, seen_good_next;

  logic        is_byte;
  logic        gap_hit;
  logic [4:0]  pos_inc;
  logic        len_ok;
  logic        sum_match;
  logic        cmd_match;
  logic        commit;
  logic        store_we;
  logic [31:0] good_age;
  ifd_pkg::ev_t ev;

  // Byte gap forces resync to the length state
  assign is_byte   = (command == ifd_pkg::CMD_BYTE);
  assign gap_hit   = (now_ms - last_byte_time) >= {24'd0, gap_ms};
  assign cur_phase = gap_hit ? ifd_pkg::PH_LEN : phase;

  assign pos_inc   = write_pos + 5'd1;
  assign len_ok    = (rx_byte <= MAX_LEN) && (rx_byte > ifd_pkg::FRAME_OVERHEAD);
  assign sum_match = ({rx_byte, sum_low_byte} == running_sum);
  assign cmd_match = (store[0] == expected_command);

  // Event of this item
  always_comb begin
    ev = ifd_pkg::EV_NONE;
    if (is_byte && cur_phase == ifd_pkg::PH_CKH) begin
      if (!sum_match) ev = ifd_pkg::EV_BAD;
      else if (cmd_match) ev = ifd_pkg::EV_GOOD;
      else ev = ifd_pkg::EV_OTHER;
    end
  end
  assign commit = (ev == ifd_pkg::EV_GOOD);

  // Parser state update for a received byte
  always_comb begin
    phase_next        = cur_phase;
    payload_len_next  = payload_len;
    write_pos_next    = write_pos;
    running_sum_next  = running_sum;
    sum_low_byte_next = sum_low_byte;
    unique case (cur_phase)
      ifd_pkg::PH_LEN: begin
        if (len_ok) begin
          write_pos_next   = 5'd0;
          payload_len_next = 5'(rx_byte - ifd_pkg::FRAME_OVERHEAD);
          running_sum_next = ifd_pkg::SUM_INIT - {8'd0, rx_byte};
          phase_next       = ifd_pkg::PH_DATA;
        end
      end
      ifd_pkg::PH_DATA: begin
        write_pos_next   = pos_inc;
        running_sum_next = running_sum - {8'd0, rx_byte};
        if (pos_inc == payload_len) phase_next = ifd_pkg::PH_CKL;
      end
      ifd_pkg::PH_CKL: begin
        sum_low_byte_next = rx_byte;
        phase_next        = ifd_pkg::PH_CKH;
      end
      ifd_pkg::PH_CKH: begin
        phase_next = ifd_pkg::PH_LEN;
      end
      default: begin
        phase_next = ifd_pkg::PH_LEN;
      end
    endcase
  end

  // Counters, good-frame time and link status after this item
  assign good_count_next = good_count + {31'd0, commit};
  assign bad_count_next  = bad_count + {31'd0, (ev == ifd_pkg::EV_BAD)};
  assign last_good_next  = commit ? now_ms : last_good_time;
  assign seen_good_next  = seen_good | commit;
  assign good_age        = now_ms - last_good_next;

  assign res.ev   = ev;
  assign res.link = seen_good_next && (good_age <= {16'd0, timeout_ms});
  assign res.good = good_count_next;
  assign res.bad  = bad_count_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ifd_pkg::PH_LEN;
      payload_len    <= '0;
      write_pos      <= '0;
      running_sum    <= '0;
      sum_low_byte   <= '0;
      last_byte_time <= '0;
      last_good_time <= '0;
      good_count     <= '0;
      bad_count      <= '0;
      seen_good      <= 1'b0;
    end else if (fire && is_byte) begin
      phase          <= phase_next;
      payload_len    <= payload_len_next;
      write_pos      <= write_pos_next;
      running_sum    <= running_sum_next;
      sum_low_byte   <= sum_low_byte_next;
      last_byte_time <= now_ms;
      last_good_time <= last_good_next;
      good_count     <= good_count_next;
      bad_count      <= bad_count_next;
      seen_good      <= seen_good_next;
    end
  end

  // Payload store, one byte per data byte
  assign store_we = fire && is_byte && (cur_phase == ifd_pkg::PH_DATA) &&
                    ({1'b0, write_pos} < STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (store_we) store[write_pos[STORE_AW-1:0]] <= rx_byte;
  end

  // Channel k takes payload bytes 2k+1 (low) and 2k+2 (high) when present
  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    if (2 * k + 2 < MAX_FRAME_BYTES) begin : g_live
      assign ch_we[k]    = commit && (5'(2 * k + 2) < payload_len);
      assign ch_wdata[k] = {store[2 * k + 2], store[2 * k + 1]};
    end else begin : g_dead
      assign ch_we[k]    = 1'b0;
      assign ch_wdata[k] = 16'd0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ifd_burst.sv
// Result stage: channel table, result register and channel burst sequencer.
`default_nettype none

module ifd_burst #(
  parameter int CHANNELS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ifd_pkg::item_res_t   res,
  input  logic [CHANNELS-1:0]  ch_we,
  input  logic [15:0]          ch_wdata [CHANNELS],
  output logic                 take,
  ifd_result_if.source         result
);

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] LAST_IDX = 4'(CHANNELS - 1);

  logic         out_valid;
  ifd_pkg::ev_t ev_q;
  logic [3:0]   idx;
  logic         last_q;
  logic         link_q;
  logic [31:0]  good_q;
  logic [31:0]  bad_q;
  logic [15:0]  ch_table [CHANNELS];
  logic         adv;
  logic         is_good;

  // Free for a new item once the final result of the current one leaves
  assign take    = !out_valid || (result.ready && last_q);
  assign adv     = out_valid && result.ready && !last_q;
  assign is_good = (ev_q == ifd_pkg::EV_GOOD);

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && result.ready && last_q) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload and burst position
  always_ff @(posedge clk) begin
    if (load) begin
      ev_q   <= res.ev;
      idx    <= 4'd0;
      last_q <= (res.ev != ifd_pkg::EV_GOOD) || (LAST_IDX == 4'd0);
      link_q <= res.link;
      good_q <= res.good;
      bad_q  <= res.bad;
    end else if (adv) begin
      idx    <= idx + 4'd1;
      last_q <= ((idx + 4'd1) == LAST_IDX);
    end
  end

  // Channel table, updated when a good frame commits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) ch_table[k] <= 16'd0;
    end else if (load) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (ch_we[k]) ch_table[k] <= ch_wdata[k];
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.event_res     = ev_q;
  assign result.channel_index = idx;
  assign result.channel_value = is_good ? ch_table[idx[CH_AW-1:0]] : 16'd0;
  assign result.last          = last_q;
  assign result.link_ok       = link_q;
  assign result.good_frames   = good_q;
  assign result.bad_frames    = bad_q;

endmodule

`default_nettype wire

### hw/rtl/ibus_frame_decoder_top.sv
// iBUS receiver frame decoder top level.
// Channels: item (sink) carries one transaction per received serial byte or
// time tick (command, rx_byte, now_ms); result (source) carries result items;
// cfg (sink) writes gap_ms, timeout_ms or expected_command by reg_index and is
// always ready. Every channel moves a transaction when valid and ready are high.
// Flow: an accepted item is parsed straight from the input register once the
// result stage is free, and its first result is then loaded into the result register.
// Throughput: one item per cycle while each item yields a single result and
// result.ready stays high; a good channel frame yields CHANNELS results, one per
// cycle unless result.ready is low; the next item is parsed when the final one
// is taken. The result register and the burst counter set that figure.
// Reset (rst, synchronous): parser back to the length state, counters, channel
// table and times cleared, registers at 3 ms, 500 ms and 0x40.
// Receiver stall: the result is held stable; one more item is still taken into
// the input register, then item.ready drops until the final result is taken.
`default_nettype none

module ibus_frame_decoder_top #(
  parameter int CHANNELS        = 14,
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  ifd_item_if.sink      item,
  ifd_result_if.source  result,
  ifd_cfg_if.sink       cfg
);

  logic [7:0]  gap_ms_q;
  logic [15:0] timeout_ms_q;
  logic [7:0]  expected_cmd_q;

  logic        in_valid;
  logic        in_command;
  logic [7:0]  in_byte;
  logic [31:0] in_now;
  logic        take;
  logic        fire;

  ifd_pkg::item_res_t    res;
  logic [CHANNELS-1:0]   ch_we;
  logic [15:0]           ch_wdata [CHANNELS];

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms_q       <= ifd_pkg::GAP_MS_RST;
      timeout_ms_q   <= ifd_pkg::TIMEOUT_MS_RST;
      expected_cmd_q <= ifd_pkg::EXPECTED_CMD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        ifd_pkg::REG_GAP_MS:       gap_ms_q       <= cfg.wdata[7:0];
        ifd_pkg::REG_TIMEOUT_MS:   timeout_ms_q   <= cfg.wdata;
        ifd_pkg::REG_EXPECTED_CMD: expected_cmd_q <= cfg.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign fire       = in_valid && take;
  assign item.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_command <= item.command;
      in_byte    <= item.rx_byte;
      in_now     <= item.now_ms;
    end
  end

  ifd_parser #(
    .CHANNELS        (CHANNELS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .command          (in_command),
    .rx_byte          (in_byte),
    .now_ms           (in_now),
    .gap_ms           (gap_ms_q),
    .timeout_ms       (timeout_ms_q),
    .expected_command (expected_cmd_q),
    .res              (res),
    .ch_we            (ch_we),
    .ch_wdata         (ch_wdata)
  );

  ifd_burst #(
    .CHANNELS (CHANNELS)
  ) u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .res      (res),
    .ch_we    (ch_we),
    .ch_wdata (ch_wdata),
    .take     (take),
    .result   (result)
  );

endmodule

`default_nettype wire

### hw/rtl/ifd_checker.sv
// Port-level checker for the iBUS frame decoder, bound to the top level.
`default_nettype none

`include "ibus_frame_decoder_top_assert.svh"

module ifd_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  result_event,
  input logic [3:0]  result_index,
  input logic [15:0] result_value,
  input logic        result_last,
  input logic        result_link,
  input logic [31:0] result_good,
  input logic [31:0] result_bad
);

  // Results other than a good frame carry no channel and close their item
  `IFD_ASSERT_IMP(a_plain_result, result_valid && result_event != ifd_pkg::EV_GOOD, result_index == 4'd0 && result_value == 16'd0 && result_last)

  // A good frame always reports the link as up
  `IFD_ASSERT_IMP(a_good_link, result_valid && result_event == ifd_pkg::EV_GOOD, result_link)

  // Inside a burst the next channel follows at once
  `IFD_ASSERT_NXT(a_burst_step, result_valid && result_ready && result_event == ifd_pkg::EV_GOOD && !result_last, result_valid && result_event == ifd_pkg::EV_GOOD && result_index == 4'($past(result_index) + 4'd1))

  // A stalled result holds
  `IFD_ASSERT_NXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result_event) && $stable(result_index) && $stable(result_value) && $stable(result_good) && $stable(result_bad))

endmodule

bind ibus_frame_decoder_top ifd_checker u_ifd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_event (result.event_res),
  .result_index (result.channel_index),
  .result_value (result.channel_value),
  .result_last  (result.last),
  .result_link  (result.link_ok),
  .result_good  (result.good_frames),
  .result_bad   (result.bad_frames)
);

`default_nettype wire
